// ===== sv/lfuac_pkg.sv =====
// shared types and constants for the lfu admission cache
// no dependencies; imported by the victim scan, the top level and the checker
package lfuac_pkg;

  localparam int LAYERS_DEF     = 64;
  localparam int EXPERTS_DEF    = 256;
  localparam int COUNT_BITS_DEF = 32;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 112;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 9;
  localparam int TOTAL_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPERTS_IN_USE = 1'd1;

  localparam logic [CFG_W-1:0] SLOT_CAPACITY_RST  = 9'd26;
  localparam logic [CFG_W-1:0] EXPERTS_IN_USE_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_HIT     = 3'd1,
    ST_FREE    = 3'd2,
    ST_EVICT   = 3'd3,
    ST_BYPASS  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EVAL,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_EVICT_OLD,
    S_EVICT_NEW,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic sample;
  } scan_ctl_t;

endpackage

// ===== sv/lfuac_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
// depends on nothing
module lfuac_ram #(
  parameter int WIDTH  = 33,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lfuac_victim_scan.sv =====
// running minimum over the resident entries of one layer
// depends on lfuac_pkg for the scan control struct
module lfuac_victim_scan #(
  parameter int COUNT_BITS = 32,
  parameter int EXP_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lfuac_pkg::scan_ctl_t   ctl,
  input  logic [EXP_W-1:0]       sample_idx,
  input  logic                   sample_res,
  input  logic [COUNT_BITS-1:0]  sample_count,
  output logic                   found,
  output logic [COUNT_BITS-1:0]  best,
  output logic [EXP_W-1:0]       cold
);
  import lfuac_pkg::*;

  logic take;

  // strict less-than keeps the lowest index on ties
  assign take = ctl.sample && sample_res && (!found || (sample_count < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best <= sample_count;
      cold <= sample_idx;
    end
  end

endmodule

// ===== sv/lfu_admission_cache_top.sv =====
// lfu admission cache top: per-layer lfu caches with admission filter
// depends on lfuac_pkg, lfuac_ram, lfuac_victim_scan
// one request at a time; the result is valid in the same cycle as the next request can be taken;
//   request kinds: ignored, hit, free-slot fill, full-layer miss with bypass or eviction; the
//   victim scan reads one entry per cycle, and a stalled result holds up the next request
// reset: synchronous, then a clearing pass over LAYERS x EXPERTS entries (each rounded up to 2^n)
module lfu_admission_cache_top #(
  parameter int LAYERS     = lfuac_pkg::LAYERS_DEF,
  parameter int EXPERTS    = lfuac_pkg::EXPERTS_DEF,
  parameter int COUNT_BITS = lfuac_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request: layer [5:0], expert_id [13:6], zero pad [15:14]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lfuac_pkg::IN_W-1:0]      s_tdata,
  // result: status [2:0], victim_id [10:3], touch_count [42:11],
  //   hit_total [74:43], miss_total [106:75], zero pad [111:107]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lfuac_pkg::OUT_W-1:0]     m_tdata,
  input  logic                            cfg_wen,
  input  logic [lfuac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfuac_pkg::CFG_W-1:0]     cfg_data
);
  import lfuac_pkg::*;

  localparam int LW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int EW  = $clog2(EXPERTS);
  localparam int AW  = LW + EW;
  localparam int MW  = COUNT_BITS + 1;

  // configuration registers
  logic [CFG_W-1:0] slot_capacity;
  logic [CFG_W-1:0] experts_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_capacity  <= SLOT_CAPACITY_RST;
      experts_in_use <= EXPERTS_IN_USE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SLOT_CAPACITY:  slot_capacity  <= cfg_data;
        REG_EXPERTS_IN_USE: experts_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // request decode
  logic [5:0]  in_layer;
  logic [7:0]  in_id;
  logic [7:0]  layer8;
  logic [9:0]  id10;
  logic        in_ok;

  assign in_layer = s_tdata[5:0];
  assign in_id    = s_tdata[13:6];
  assign layer8   = {2'b00, in_layer};
  assign id10     = {2'b00, in_id};
  assign in_ok    = ({1'b0, layer8} < 9'(LAYERS))
                 && ({1'b0, in_id} < experts_in_use)
                 && ({3'b000, in_id} < 11'(EXPERTS));

  // control and request registers
  state_t state, state_next;
  logic [AW-1:0]  clr_addr;
  logic [LW-1:0]  lyr_q;
  logic [EW-1:0]  id_q;
  logic [EW-1:0]  scan_idx;
  logic           sample_vld;
  logic [EW-1:0]  sample_idx;

  status_t              res_status;
  logic [7:0]           res_victim;
  logic [COUNT_BITS-1:0] res_count;
  logic [TOTAL_W-1:0]   hits_seen;
  logic [TOTAL_W-1:0]   misses_seen;

  logic                 out_valid;
  logic [OUT_W-1:0]     out_data;

  // memories: {resident, count} per entry, occupancy per layer
  logic           cnt_we, cnt_re;
  logic [AW-1:0]  cnt_waddr, cnt_raddr;
  logic [MW-1:0]  cnt_wdata, cnt_rdata;
  logic           occ_we, occ_re;
  logic [LW-1:0]  occ_waddr;
  logic [CFG_W-1:0] occ_wdata, occ_rdata;

  lfuac_ram #(.WIDTH(MW), .ADDR_W(AW)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_en   (cnt_re),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  lfuac_ram #(.WIDTH(CFG_W), .ADDR_W(LW)) u_occ_ram (
    .clk     (clk),
    .wr_en   (occ_we),
    .wr_addr (occ_waddr),
    .wr_data (occ_wdata),
    .rd_en   (occ_re),
    .rd_addr (lyr_q),
    .rd_data (occ_rdata)
  );

  // victim scan
  scan_ctl_t             scan_ctl;
  logic                  vs_found;
  logic [COUNT_BITS-1:0] vs_best;
  logic [EW-1:0]         vs_cold;

  lfuac_victim_scan #(.COUNT_BITS(COUNT_BITS), .EXP_W(EW)) u_scan (
    .clk          (clk),
    .rst          (rst),
    .ctl          (scan_ctl),
    .sample_idx   (sample_idx),
    .sample_res   (cnt_rdata[COUNT_BITS]),
    .sample_count (cnt_rdata[COUNT_BITS-1:0]),
    .found        (vs_found),
    .best         (vs_best),
    .cold         (vs_cold)
  );

  // entry evaluation, valid while in the eval state
  logic                  ent_res;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  occ_free;
  logic                  admit;
  logic                  out_load;
  logic [TOTAL_W-1:0]    touch32;

  assign ent_res  = cnt_rdata[COUNT_BITS];
  assign ent_cnt  = cnt_rdata[COUNT_BITS-1:0];
  assign cnt_inc  = (ent_cnt == '1) ? ent_cnt : ent_cnt + 1'b1;
  assign occ_free = occ_rdata < slot_capacity;
  // a full layer with nothing resident falls through to bypass
  assign admit    = vs_found && (res_count > vs_best);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_we     = 1'b0;
    cnt_waddr  = {lyr_q, id_q};
    cnt_wdata  = '0;
    cnt_re     = 1'b0;
    cnt_raddr  = {lyr_q, id_q};
    occ_we     = 1'b0;
    occ_re     = 1'b0;
    occ_waddr  = lyr_q;
    occ_wdata  = '0;
    scan_ctl   = '0;
    out_load   = 1'b0;
    scan_ctl.sample = sample_vld;
    unique case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        occ_we    = 1'b1;
        occ_waddr = clr_addr[LW-1:0];
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = in_ok ? S_LOOKUP : S_FINISH;
        end
      end
      S_LOOKUP: begin
        cnt_re     = 1'b1;
        occ_re     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cnt_we = 1'b1;
        if (ent_res) begin
          cnt_wdata  = {1'b1, cnt_inc};
          state_next = S_FINISH;
        end else if (occ_free) begin
          cnt_wdata  = {1'b1, cnt_inc};
          occ_we     = 1'b1;
          occ_wdata  = occ_rdata + 1'b1;
          state_next = S_FINISH;
        end else begin
          // count is written back before the scan reads the layer
          cnt_wdata      = {1'b0, cnt_inc};
          scan_ctl.start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_re    = 1'b1;
        cnt_raddr = {lyr_q, scan_idx};
        if (scan_idx == EW'(EXPERTS - 1)) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = admit ? S_EVICT_OLD : S_FINISH;
      end
      S_EVICT_OLD: begin
        cnt_we     = 1'b1;
        cnt_waddr  = {lyr_q, vs_cold};
        cnt_wdata  = {1'b0, vs_best};
        state_next = S_EVICT_NEW;
      end
      S_EVICT_NEW: begin
        cnt_we     = 1'b1;
        cnt_wdata  = {1'b1, res_count};
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_vld <= 1'b0;
    end else begin
      sample_vld <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    sample_idx <= scan_idx;
    if (state == S_EVAL) begin
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // per-request datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      lyr_q      <= layer8[LW-1:0];
      id_q       <= id10[EW-1:0];
      res_status <= ST_IGNORED;
      res_victim <= '0;
      res_count  <= '0;
    end
    if (state == S_EVAL) begin
      res_count <= cnt_inc;
      if (ent_res) begin
        res_status <= ST_HIT;
      end else if (occ_free) begin
        res_status <= ST_FREE;
      end
    end
    if (state == S_DECIDE) begin
      if (admit) begin
        res_status <= ST_EVICT;
        res_victim <= 8'(vs_cold);
      end else begin
        res_status <= ST_BYPASS;
      end
    end
  end

  // saturating totals
  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen   <= '0;
      misses_seen <= '0;
    end else if (state == S_EVAL) begin
      if (ent_res) begin
        if (hits_seen != '1) hits_seen <= hits_seen + 1'b1;
      end else begin
        if (misses_seen != '1) misses_seen <= misses_seen + 1'b1;
      end
    end
  end

  // touch count reported on 32 bits
  generate
    if (COUNT_BITS > TOTAL_W) begin : g_sat
      assign touch32 = (|res_count[COUNT_BITS-1:TOTAL_W]) ? '1 : res_count[TOTAL_W-1:0];
    end else begin : g_ext
      assign touch32 = TOTAL_W'(res_count);
    end
  endgenerate

  // output register, parts the result from the request side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {5'b00000, misses_seen, hits_seen, touch32, res_victim, res_status};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== sv/lfuac_checker.sv =====
// port-level checks for the lfu admission cache, bound to the top level
// depends on lfuac_pkg and lfu_admission_cache_top
module lfuac_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lfuac_pkg::OUT_W-1:0]     m_tdata
);
  import lfuac_pkg::*;

  // no request is taken while the clearing pass runs
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request port ready straight after reset");

  // victim only reported with an eviction
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] != ST_EVICT)) |-> (m_tdata[10:3] == 8'd0))
    else $error("victim id set without eviction");

  // an ignored request reports zero count, every other one at least one touch
  a_count_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[2:0] == ST_IGNORED) == (m_tdata[42:11] == 32'd0)))
    else $error("touch count does not match status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind lfu_admission_cache_top lfuac_checker u_lfuac_checker (.*);

// ===== dv/lfu_admission_cache_top_test.sv =====
// self-checking testbench for lfu_admission_cache_top: directed cases, then random phases
// keeps its own per-layer lfu model and compares every result field by field
// depends on lfuac_pkg and lfu_admission_cache_top
`timescale 1ns / 100ps

module lfu_admission_cache_top_test;
  import lfuac_pkg::*;

  localparam int NUM_LAYERS  = LAYERS_DEF;
  localparam int NUM_EXPERTS = EXPERTS_DEF;
  // longest run of cycles with no handshake: clearing pass after reset plus margin
  localparam int QUIET_LIMIT = 100000;
  // idle tail after the final drain, longer than a full-layer miss lasts
  localparam int TAIL_CYCLES = 300;

  // one predicted outcome of a request
  typedef struct {
    status_t     status;
    logic [7:0]  victim;
    logic [31:0] count;
    logic [31:0] hits;
    logic [31:0] misses;
  } access_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // layer [5:0], expert_id [13:6], zero pad [15:14]
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  // status [2:0], victim_id [10:3], touch_count [42:11], hit_total [74:43],
  // miss_total [106:75], zero pad [111:107]
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // model of the cache contents, cleared like the block at reset
  bit [31:0] touch_cnt [NUM_LAYERS][NUM_EXPERTS];
  bit        resident  [NUM_LAYERS][NUM_EXPERTS];
  int        occupied  [NUM_LAYERS];
  bit [31:0] hit_tally;
  bit [31:0] miss_tally;
  int        cap_setting;
  int        id_limit;

  access_result_t pending_results[$];
  int             errors;
  int             quiet_cycles;
  bit             no_gaps;

  lfu_admission_cache_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // prediction: one access to the per-layer lfu cache with admission filter
  // ---------------------------------------------------------------------------
  function automatic access_result_t predict_access(logic [5:0] layer, logic [7:0] id);
    access_result_t r;
    bit             found;
    int             coldest;
    bit [31:0]      best;
    r.status = ST_IGNORED;
    r.victim = '0;
    r.count  = '0;
    found    = 1'b0;
    coldest  = 0;
    best     = '0;
    // ids at or above the configured count change nothing
    if (int'(id) < id_limit) begin
      if (touch_cnt[layer][id] != 32'hFFFF_FFFF) begin
        touch_cnt[layer][id] = touch_cnt[layer][id] + 1;
      end
      r.count = touch_cnt[layer][id];
      if (resident[layer][id]) begin
        r.status = ST_HIT;
        if (hit_tally != 32'hFFFF_FFFF) hit_tally = hit_tally + 1;
      end else begin
        if (miss_tally != 32'hFFFF_FFFF) miss_tally = miss_tally + 1;
        if (occupied[layer] < cap_setting) begin
          resident[layer][id] = 1'b1;
          occupied[layer]++;
          r.status = ST_FREE;
        end else begin
          // coldest resident over the whole layer, lowest index wins ties;
          // stale residents above the id limit are still candidates
          for (int x = 0; x < NUM_EXPERTS; x++) begin
            if (resident[layer][x] && (!found || touch_cnt[layer][x] < best)) begin
              found   = 1'b1;
              best    = touch_cnt[layer][x];
              coldest = x;
            end
          end
          // admit only when strictly hotter than the coldest resident
          if (found && r.count > best) begin
            resident[layer][coldest] = 1'b0;
            resident[layer][id]      = 1'b1;
            r.status = ST_EVICT;
            r.victim = coldest[7:0];
          end else begin
            r.status = ST_BYPASS;
          end
        end
      end
    end
    r.hits   = hit_tally;
    r.misses = miss_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_access(input logic [5:0] layer, input logic [7:0] id);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, id, layer};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.insert(pending_results.size(), predict_access(layer, id));
    @(negedge clk);
  endtask

  // hold requests back until every outstanding result has come out
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // both registers are written while the block is idle
  task automatic configure(input int cap, input int lim);
    drain();
    cfg_wen   <= 1'b1;
    cfg_index <= REG_SLOT_CAPACITY;
    cfg_data  <= CFG_W'(cap);
    @(negedge clk);
    cfg_index <= REG_EXPERTS_IN_USE;
    cfg_data  <= CFG_W'(lim);
    @(negedge clk);
    cfg_wen   <= 1'b0;
    cap_setting = cap & 9'h1FF;
    id_limit    = lim & 9'h1FF;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall before each result, sometimes none at all
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // every accepted result is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
        check_field("victim_id", 32'(want.victim), 32'(m_tdata[10:3]));
        check_field("touch_count", want.count, m_tdata[42:11]);
        check_field("hit_total", want.hits, m_tdata[74:43]);
        check_field("miss_total", want.misses, m_tdata[106:75]);
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((s_tvalid === 1'b1 && s_tready === 1'b1)
        || (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lfu_admission_cache_top_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // default registers: fills at the field extremes, then a hit on each
  task automatic test_reset_defaults;
    send_access(6'd0, 8'd0);
    send_access(6'd63, 8'd255);
    send_access(6'd0, 8'd0);
    send_access(6'd63, 8'd255);
  endtask

  // zero experts in use ignores everything; one in use admits only id 0
  task automatic test_ignored_ids;
    configure(26, 0);
    send_access(6'd5, 8'd0);
    send_access(6'd5, 8'd255);
    configure(26, 1);
    send_access(6'd5, 8'd1);
    send_access(6'd5, 8'd0);
  endtask

  // full layer: tie on count means bypass, a hotter request evicts the lowest index
  task automatic test_eviction_and_bypass;
    configure(2, 256);
    send_access(6'd10, 8'd3);
    send_access(6'd10, 8'd4);
    send_access(6'd10, 8'd5);
    send_access(6'd10, 8'd5);
  endtask

  // residents left above a lowered id limit are ignored but still evictable
  task automatic test_stale_residents;
    configure(2, 256);
    send_access(6'd11, 8'd200);
    send_access(6'd11, 8'd201);
    configure(2, 100);
    send_access(6'd11, 8'd201);
    send_access(6'd11, 8'd7);
    send_access(6'd11, 8'd7);
  endtask

  // zero capacity on an empty layer: full but nothing to evict, so bypass
  task automatic test_zero_capacity;
    configure(0, 256);
    send_access(6'd12, 8'd1);
  endtask

  // capacity lowered below occupancy: one eviction per admission
  task automatic test_capacity_below_occupancy;
    configure(3, 256);
    send_access(6'd13, 8'd20);
    send_access(6'd13, 8'd21);
    send_access(6'd13, 8'd22);
    configure(1, 256);
    send_access(6'd13, 8'd9);
    send_access(6'd13, 8'd9);
  endtask

  // ---------------------------------------------------------------------------
  // random phase: mostly a few hot layers and a skewed set of hot ids so that
  // layers fill and counts diverge, with some requests spread over all fields
  // ---------------------------------------------------------------------------
  task automatic test_random(input int n, input int cap, input int lim,
                             input int hot_layers, input int hot_ids, input bit steady);
    logic [5:0] layer;
    logic [7:0] id;
    configure(cap, lim);
    no_gaps = steady;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        layer = 6'($urandom_range(0, NUM_LAYERS - 1));
        id    = 8'($urandom_range(0, NUM_EXPERTS - 1));
      end else begin
        layer = 6'($urandom_range(0, hot_layers - 1));
        id    = 8'($urandom_range(0, $urandom_range(0, hot_ids - 1)));
      end
      send_access(layer, id);
      // now and then let the block run completely dry
      if ($urandom_range(0, 99) == 0) drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    cfg_wen     = 1'b0;
    cfg_index   = REG_SLOT_CAPACITY;
    cfg_data    = '0;
    no_gaps     = 1'b0;
    hit_tally   = '0;
    miss_tally  = '0;
    cap_setting = int'(SLOT_CAPACITY_RST);
    id_limit    = int'(EXPERTS_IN_USE_RST);
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_ignored_ids();
    test_eviction_and_bypass();
    test_stale_residents();
    test_zero_capacity();
    test_capacity_below_occupancy();

    test_random(300, 4, 256, 4, 12, 1'b0);
    test_random(250, 1, 16, 2, 24, 1'b1);
    test_random(300, 8, 200, 3, 32, 1'b0);
    test_random(100, 0, 256, 4, 16, 1'b0);
    test_random(250, 26, 40, 2, 48, 1'b0);
    test_random(200, 256, 256, 8, 256, 1'b0);
    test_random(200, 3, 255, 4, 10, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("lfu_admission_cache_top_test: clean");
    end else begin
      $display("lfu_admission_cache_top_test: errors");
    end
    $finish;
  end

endmodule
